>>> src/bcpt_pkg.sv
// Package for the beat clock phase tracker.
// Holds the configuration struct, register indexes, command codes and fixed constants.
// No dependencies.
package bcpt_pkg;

  // Width of the tempo register and of the interval/remainder datapath.
  localparam int BPM_W      = 10;
  localparam int IVL_BITS   = 16;
  localparam int IVL_IDX_W  = $clog2(IVL_BITS);
  localparam int REM_W      = IVL_BITS;

  localparam logic [IVL_BITS-1:0] MS_PER_MINUTE = 16'd60000;
  localparam logic [BPM_W-1:0]    RESET_BPM     = 10'd120;

  // Configuration register indexes (byte address bit 2).
  localparam logic REG_TEMPO  = 1'b0;
  localparam logic REG_SOURCE = 1'b1;

  // Input commands.
  localparam logic CMD_TICK    = 1'b0;
  localparam logic CMD_TRIGGER = 1'b1;

  // Beat source selections.
  localparam logic SRC_TEMPO = 1'b0;
  localparam logic SRC_SOUND = 1'b1;

  typedef struct packed {
    logic [BPM_W-1:0] tempo_bpm;
    logic             beat_source;
  } cfg_t;

endpackage

>>> src/bcpt_in_if.sv
// Input channel of the beat clock phase tracker: command and millisecond time.
// Valid/ready handshake; width of now_ms follows TIME_WIDTH.
interface bcpt_in_if #(
  parameter int TIME_WIDTH = 32
);
  logic                  valid;
  logic                  ready;
  logic                  command;
  logic [TIME_WIDTH-1:0] now_ms;

  modport source (output valid, output command, output now_ms, input ready);
  modport sink   (input valid, input command, input now_ms, output ready);
endinterface

>>> src/bcpt_out_if.sv
// Result channel of the beat clock phase tracker: pulse, count, phase and LED.
// Valid/ready handshake; width of beat_phase follows PHASE_FRAC_BITS.
interface bcpt_out_if #(
  parameter int PHASE_FRAC_BITS = 16
);
  logic                     valid;
  logic                     ready;
  logic                     beat_pulse;
  logic [31:0]              beat_number;
  logic [PHASE_FRAC_BITS:0] beat_phase;
  logic                     beat_led;

  modport source (output valid, output beat_pulse, output beat_number, output beat_phase,
                  output beat_led, input ready);
  modport sink   (input valid, input beat_pulse, input beat_number, input beat_phase,
                  input beat_led, output ready);
endinterface

>>> src/beat_clock_phase_tracker_core.sv
// Beat clock phase tracker, top level.
// Uses bcpt_pkg, bcpt_in_if, bcpt_out_if, bcpt_div_step and bcpt_cfg_regs.
//
// Usage:
//   in_ch   valid/ready; command 0 is a frame tick carrying now_ms, command 1 a
//           sound trigger. A trigger gives no result.
//   out_ch  valid/ready; one result per frame tick: beat_pulse, beat_number,
//           beat_phase (2^PHASE_FRAC_BITS = one beat) and beat_led.
//   cfg_*   APB-style writes to tempo_bpm (0x0) and beat_source (0x4), pready high.
// Sequence: a frame tick in tempo mode divides out the beat interval
//   (60000 / bpm, one quotient bit per cycle), compares the elapsed time,
//   runs the phase division on the same shared divider step and loads the
//   result. A beat advance skips the phase division and may snap the reference
//   to now before the load; a tick landing exactly on the interval skips it too.
//   The next tick is accepted in the cycle after the load. In sound mode a
//   frame tick goes straight to the result load. in_ch.ready is low meanwhile.
// The result sits in an output register; the next tick is accepted while it
//   waits, and a finished tick holds until the register frees up.
// Reset (rst_n low, synchronous) clears the beat count, reference time, LED and
//   output valid flag, and sets tempo 120 bpm in tempo mode.
module beat_clock_phase_tracker_core #(
  parameter int TIME_WIDTH      = 32,
  parameter int PHASE_FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  bcpt_in_if.sink     in_ch,
  bcpt_out_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  localparam int STEPS_MAX = (bcpt_pkg::IVL_BITS > PHASE_FRAC_BITS) ?
                             bcpt_pkg::IVL_BITS : PHASE_FRAC_BITS;
  localparam int CNT_W = $clog2(STEPS_MAX);
  localparam int QW    = STEPS_MAX;
  localparam int PH_W  = PHASE_FRAC_BITS + 1;
  localparam logic [PH_W-1:0] PHASE_ONE = {1'b1, {PHASE_FRAC_BITS{1'b0}}};

  typedef enum logic [2:0] {
    S_IDLE,
    S_IVL,
    S_CHECK,
    S_PHASE,
    S_DONE
  } state_t;

  bcpt_pkg::cfg_t cfg;

  bcpt_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  state_t                      state_r, state_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [bcpt_pkg::REM_W-1:0]  rem_r, rem_nxt;
  logic [QW-1:0]               quo_r, quo_nxt;
  logic [bcpt_pkg::IVL_BITS-1:0] ivl_r, ivl_nxt;
  logic [TIME_WIDTH-1:0]       now_r, now_nxt;
  logic [TIME_WIDTH-1:0]       ref_r, ref_nxt;
  logic [31:0]                 bcnt_r, bcnt_nxt;
  logic [31:0]                 seen_r, seen_nxt;
  logic                        led_r, led_nxt;
  logic [PH_W-1:0]             phase_r, phase_nxt;
  logic                        adv_r, adv_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_pulse_r, out_pulse_nxt;
  logic [31:0]                 out_num_r, out_num_nxt;
  logic [PH_W-1:0]             out_phase_r, out_phase_nxt;
  logic                        out_led_r, out_led_nxt;

  logic [bcpt_pkg::BPM_W-1:0]    bpm_eff;
  logic [bcpt_pkg::REM_W-1:0]    div_w;
  logic                          bit_w;
  logic [bcpt_pkg::REM_W-1:0]    step_rem;
  logic                          step_q;
  logic [bcpt_pkg::IVL_BITS-1:0] ivl_w;
  logic [TIME_WIDTH-1:0]         ivl_ext;
  logic [TIME_WIDTH-1:0]         elapsed_w;
  logic                          load_w;
  logic                          changed_w;

  // A tempo of zero runs as 1 bpm.
  assign bpm_eff = (cfg.tempo_bpm == '0) ? bcpt_pkg::BPM_W'(1) : cfg.tempo_bpm;

  // Interval pass feeds the dividend 60000 MSB first; phase pass shifts in zeros.
  assign div_w = (state_r == S_IVL) ? bcpt_pkg::REM_W'(bpm_eff) : ivl_r;
  assign bit_w = (state_r == S_IVL) ? bcpt_pkg::MS_PER_MINUTE[cnt_r[bcpt_pkg::IVL_IDX_W-1:0]]
                                    : 1'b0;

  bcpt_div_step u_step (
    .rem_i (rem_r),
    .bit_i (bit_w),
    .div_i (div_w),
    .rem_o (step_rem),
    .q_o   (step_q)
  );

  assign ivl_w     = quo_r[bcpt_pkg::IVL_BITS-1:0];
  assign ivl_ext   = TIME_WIDTH'(ivl_w);
  assign elapsed_w = now_r - ref_r;
  assign changed_w = (seen_r != bcnt_r);
  assign load_w    = (state_r == S_DONE) && !adv_r && (!out_valid_r || out_ch.ready);

  assign in_ch.ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    ivl_nxt       = ivl_r;
    now_nxt       = now_r;
    ref_nxt       = ref_r;
    bcnt_nxt      = bcnt_r;
    seen_nxt      = seen_r;
    led_nxt       = led_r;
    phase_nxt     = phase_r;
    adv_nxt       = adv_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_pulse_nxt = out_pulse_r;
    out_num_nxt   = out_num_r;
    out_phase_nxt = out_phase_r;
    out_led_nxt   = out_led_r;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.command == bcpt_pkg::CMD_TRIGGER) begin
            if (cfg.beat_source == bcpt_pkg::SRC_SOUND) begin
              bcnt_nxt = bcnt_r + 32'd1;
            end
          end else begin
            now_nxt = in_ch.now_ms;
            adv_nxt = 1'b0;
            if (cfg.beat_source == bcpt_pkg::SRC_SOUND) begin
              phase_nxt = PHASE_ONE;
              state_nxt = S_DONE;
            end else begin
              rem_nxt   = '0;
              quo_nxt   = '0;
              cnt_nxt   = CNT_W'(bcpt_pkg::IVL_BITS - 1);
              state_nxt = S_IVL;
            end
          end
        end
      end
      S_IVL: begin
        rem_nxt = step_rem;
        quo_nxt = {quo_r[QW-2:0], step_q};
        if (cnt_r == '0) begin
          state_nxt = S_CHECK;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      S_CHECK: begin
        ivl_nxt = ivl_w;
        if (elapsed_w > ivl_ext) begin
          bcnt_nxt  = bcnt_r + 32'd1;
          phase_nxt = '0;
          ref_nxt   = ref_r + ivl_ext;
          adv_nxt   = 1'b1;
          state_nxt = S_DONE;
        end else if (elapsed_w == ivl_ext) begin
          phase_nxt = PHASE_ONE;
          state_nxt = S_DONE;
        end else begin
          // Elapsed lies below the interval here, so it fits the remainder.
          rem_nxt   = elapsed_w[bcpt_pkg::REM_W-1:0];
          quo_nxt   = '0;
          cnt_nxt   = CNT_W'(PHASE_FRAC_BITS - 1);
          state_nxt = S_PHASE;
        end
      end
      S_PHASE: begin
        rem_nxt = step_rem;
        quo_nxt = {quo_r[QW-2:0], step_q};
        if (cnt_r == '0) begin
          phase_nxt = {1'b0, quo_nxt[PHASE_FRAC_BITS-1:0]};
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      S_DONE: begin
        if (adv_r) begin
          // Snap the reference to now when beats were missed.
          if (ref_r < now_r) begin
            ref_nxt = now_r;
          end
          adv_nxt = 1'b0;
        end else if (load_w) begin
          out_valid_nxt = 1'b1;
          out_pulse_nxt = changed_w;
          out_num_nxt   = bcnt_r;
          out_phase_nxt = phase_r;
          out_led_nxt   = led_r ^ changed_w;
          seen_nxt      = bcnt_r;
          led_nxt       = led_r ^ changed_w;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ref_r       <= '0;
      bcnt_r      <= '0;
      seen_r      <= '0;
      led_r       <= 1'b0;
      adv_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ref_r       <= ref_nxt;
      bcnt_r      <= bcnt_nxt;
      seen_r      <= seen_nxt;
      led_r       <= led_nxt;
      adv_r       <= adv_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cnt_r       <= cnt_nxt;
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    ivl_r       <= ivl_nxt;
    now_r       <= now_nxt;
    phase_r     <= phase_nxt;
    out_pulse_r <= out_pulse_nxt;
    out_num_r   <= out_num_nxt;
    out_phase_r <= out_phase_nxt;
    out_led_r   <= out_led_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.beat_pulse  = out_pulse_r;
  assign out_ch.beat_number = out_num_r;
  assign out_ch.beat_phase  = out_phase_r;
  assign out_ch.beat_led    = out_led_r;

  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && (in_ch.command == bcpt_pkg::CMD_TICK) |=> !in_ch.ready)
    else $error("input ready while a frame tick is in work");

  a_rem_below_ivl: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PHASE) |-> (rem_r < ivl_r))
    else $error("phase remainder not below interval");

  a_led_toggle: assert property (@(posedge clk) disable iff (!rst_n)
    load_w && changed_w |=> (led_r != $past(led_r)) && out_ch.beat_pulse)
    else $error("beat change without LED toggle and pulse");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_ch.beat_phase <= PHASE_ONE))
    else $error("beat phase above one beat");

  a_pulse_count: assert property (@(posedge clk) disable iff (!rst_n)
    load_w |=> (seen_r == $past(bcnt_r)))
    else $error("seen count not updated at result load");

endmodule

>>> src/bcpt_div_step.sv
// One restoring-division step: shift a bit into the remainder, compare, subtract.
// Shared by the interval and phase divisions; uses bcpt_pkg for widths.
module bcpt_div_step (
  input  logic [bcpt_pkg::REM_W-1:0] rem_i,
  input  logic                       bit_i,
  input  logic [bcpt_pkg::REM_W-1:0] div_i,
  output logic [bcpt_pkg::REM_W-1:0] rem_o,
  output logic                       q_o
);
  logic [bcpt_pkg::REM_W:0] shifted;
  logic [bcpt_pkg::REM_W:0] diff;

  assign shifted = {rem_i, bit_i};
  assign diff    = shifted - {1'b0, div_i};
  assign q_o     = (shifted >= {1'b0, div_i});
  // Remainder stays below the divisor, so the top bit drops out either way.
  assign rem_o   = q_o ? diff[bcpt_pkg::REM_W-1:0] : shifted[bcpt_pkg::REM_W-1:0];
endmodule

>>> src/bcpt_cfg_regs.sv
// APB-style configuration registers: tempo_bpm at 0x0, beat_source at 0x4.
// Uses bcpt_pkg for the register struct and indexes.
module bcpt_cfg_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output bcpt_pkg::cfg_t      cfg
);
  logic [bcpt_pkg::BPM_W-1:0] tempo_r, tempo_nxt;
  logic                       source_r, source_nxt;
  logic                       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    tempo_nxt  = tempo_r;
    source_nxt = source_r;
    if (wr_en) begin
      case (paddr[2])
        bcpt_pkg::REG_TEMPO:  tempo_nxt  = pwdata[bcpt_pkg::BPM_W-1:0];
        bcpt_pkg::REG_SOURCE: source_nxt = pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tempo_r  <= bcpt_pkg::RESET_BPM;
      source_r <= bcpt_pkg::SRC_TEMPO;
    end else begin
      tempo_r  <= tempo_nxt;
      source_r <= source_nxt;
    end
  end

  always_comb begin
    case (paddr[2])
      bcpt_pkg::REG_TEMPO:  prdata = {{(32-bcpt_pkg::BPM_W){1'b0}}, tempo_r};
      bcpt_pkg::REG_SOURCE: prdata = {31'd0, source_r};
      default:              prdata = 32'd0;
    endcase
  end

  assign cfg.tempo_bpm   = tempo_r;
  assign cfg.beat_source = source_r;
endmodule

>>> tb/sv/beat_clock_phase_tracker_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for beat_clock_phase_tracker_core: directed table, then random phases.
// Depends on bcpt_pkg, bcpt_in_if, bcpt_out_if and the core; checks against a built-in predictor.
module beat_clock_phase_tracker_core_tb;

  localparam int RANDOM_ITEMS  = 1950;
  localparam int PHASE_COUNT   = 8;
  localparam int SETTLE_CYCLES = 48;

  typedef struct packed {
    logic        pulse;
    logic [31:0] number;
    logic [16:0] phase;
    logic        led;
  } beat_report_t;

  typedef struct packed {
    logic         is_cfg;
    logic         reg_sel;
    logic [31:0]  value;
    logic         cmd;
    logic [31:0]  now_ms;
    logic         typed;
    beat_report_t want;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  bcpt_in_if  #(.TIME_WIDTH(32))      in_ch ();
  bcpt_out_if #(.PHASE_FRAC_BITS(16)) out_ch ();

  beat_clock_phase_tracker_core uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Predictor state and its copy of the registers.
  logic [31:0]                ref_time_ms;
  logic [31:0]                pred_beats;
  logic [31:0]                seen_count;
  logic                       led_on;
  logic [bcpt_pkg::BPM_W-1:0] tempo_reg;
  logic                       source_reg;

  beat_report_t expected_reports[$];
  int           errors;
  int           burst_left;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin : watchdog
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic logic [15:0] tempo_interval_ms();
    logic [15:0] bpm;
    bpm = {6'd0, tempo_reg};
    if (bpm == 16'd0) bpm = 16'd1;
    return bcpt_pkg::MS_PER_MINUTE / bpm;
  endfunction

  // Advance the beat clock by one transaction; return 1 when it yields a report.
  function automatic bit predict_frame(input logic cmd, input logic [31:0] now,
                                       output beat_report_t rep);
    logic [15:0] ivl;
    logic [31:0] elapsed;
    logic [47:0] scaled;
    rep = '0;
    if (cmd == bcpt_pkg::CMD_TRIGGER) begin
      if (source_reg == bcpt_pkg::SRC_SOUND) pred_beats = pred_beats + 32'd1;
      return 1'b0;
    end
    rep.phase = 17'h10000;
    if (source_reg == bcpt_pkg::SRC_TEMPO) begin
      ivl = tempo_interval_ms();
      elapsed = now - ref_time_ms;
      if (elapsed > {16'd0, ivl}) begin
        pred_beats = pred_beats + 32'd1;
        rep.phase = '0;
        ref_time_ms = ref_time_ms + {16'd0, ivl};
        // Snap to now when beats were missed.
        if (ref_time_ms < now) ref_time_ms = now;
      end else begin
        scaled = {elapsed, 16'd0};
        rep.phase = 17'(scaled / {32'd0, ivl});
      end
    end
    if (seen_count != pred_beats) begin
      seen_count = pred_beats;
      led_on = ~led_on;
      rep.pulse = 1'b1;
    end
    rep.number = pred_beats;
    rep.led = led_on;
    return 1'b1;
  endfunction

  function automatic stim_row_t cfg_row(input logic sel, input logic [31:0] value);
    stim_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.reg_sel = sel;
    row.value = value;
    return row;
  endfunction

  function automatic stim_row_t tick_row(input logic cmd, input logic [31:0] now);
    stim_row_t row;
    row = '0;
    row.cmd = cmd;
    row.now_ms = now;
    return row;
  endfunction

  function automatic stim_row_t checked_row(input logic [31:0] now, input logic pulse,
                                            input logic [31:0] number, input logic [16:0] phase,
                                            input logic led);
    stim_row_t row;
    row = tick_row(bcpt_pkg::CMD_TICK, now);
    row.typed = 1'b1;
    row.want.pulse = pulse;
    row.want.number = number;
    row.want.phase = phase;
    row.want.led = led;
    return row;
  endfunction

  // Send one transaction, with random gaps between bursts, and record what it should yield.
  task automatic apply_item(input logic cmd, input logic [31:0] now, input logic typed,
                            input beat_report_t want);
    beat_report_t rep;
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left = burst_left - 1;
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.now_ms <= now;
    do @(posedge clk); while (!in_ch.ready);
    if (predict_frame(cmd, now, rep)) expected_reports.push_back(typed ? want : rep);
  endtask

  // Drain the block, write one register, then read it back.
  task automatic write_register(input logic sel, input logic [31:0] value);
    logic [31:0] readback_want;
    in_ch.valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {sel, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    readback_want = '0;
    if (sel == bcpt_pkg::REG_TEMPO) begin
      tempo_reg = value[bcpt_pkg::BPM_W-1:0];
      readback_want[bcpt_pkg::BPM_W-1:0] = tempo_reg;
    end else begin
      source_reg = value[0];
      readback_want[0] = source_reg;
    end
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== readback_want) begin
      $error("register %0d readback: expected %0d, got %0d", sel, readback_want, cfg_prdata);
      errors++;
    end
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Receiver: segments of always-ready, coin-flip ready, and long stalls.
  initial begin : result_stall
    int seg_left;
    int mode;
    int stall_left;
    out_ch.ready = 1'b0;
    seg_left = 0;
    mode = 0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (seg_left == 0) begin
        mode = $urandom_range(0, 2);
        seg_left = $urandom_range(50, 400);
      end
      seg_left--;
      case (mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 1) == 1);
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            out_ch.ready <= 1'b0;
          end else begin
            out_ch.ready <= 1'b1;
            if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 30);
          end
        end
      endcase
    end
  end

  always @(posedge clk) begin : report_check
    beat_report_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_reports.size() == 0) begin
        $error("unexpected result: number %0d phase %0d", out_ch.beat_number, out_ch.beat_phase);
        errors++;
      end else begin
        want = expected_reports.pop_front();
        if (out_ch.beat_pulse !== want.pulse) begin
          $error("beat_pulse: expected %0d, got %0d", want.pulse, out_ch.beat_pulse);
          errors++;
        end
        if (out_ch.beat_number !== want.number) begin
          $error("beat_number: expected %0d, got %0d", want.number, out_ch.beat_number);
          errors++;
        end
        if (out_ch.beat_phase !== want.phase) begin
          $error("beat_phase: expected %0d, got %0d", want.phase, out_ch.beat_phase);
          errors++;
        end
        if (out_ch.beat_led !== want.led) begin
          $error("beat_led: expected %0d, got %0d", want.led, out_ch.beat_led);
          errors++;
        end
      end
    end
  end

  initial begin : stimulus
    stim_row_t   script[$];
    int          phase_idx;
    int          sent;
    int          pick;
    int          ivl;
    logic [31:0] cur_ms;
    logic [31:0] now;
    logic [31:0] bpm_pick;
    logic        cmd;

    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.command = bcpt_pkg::CMD_TICK;
    in_ch.now_ms = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    errors = 0;
    burst_left = 0;
    ref_time_ms = '0;
    pred_beats = '0;
    seen_count = '0;
    led_on = 1'b0;
    tempo_reg = bcpt_pkg::RESET_BPM;
    source_reg = bcpt_pkg::SRC_TEMPO;

    // Reset state, 500 ms interval, time wrap, time going backward.
    script.push_back(checked_row(32'd0, 1'b0, 32'd0, 17'd0, 1'b0));
    script.push_back(checked_row(32'd250, 1'b0, 32'd0, 17'd32768, 1'b0));
    script.push_back(checked_row(32'd500, 1'b0, 32'd0, 17'h10000, 1'b0));
    script.push_back(checked_row(32'd501, 1'b1, 32'd1, 17'd0, 1'b1));
    script.push_back(checked_row(32'd501, 1'b0, 32'd1, 17'd0, 1'b1));
    script.push_back(tick_row(bcpt_pkg::CMD_TRIGGER, 32'hFFFF_FFFF));
    script.push_back(checked_row(32'hFFFF_FFFF, 1'b1, 32'd2, 17'd0, 1'b0));
    script.push_back(tick_row(bcpt_pkg::CMD_TICK, 32'h0000_0100));
    script.push_back(tick_row(bcpt_pkg::CMD_TICK, 32'd500));
    script.push_back(tick_row(bcpt_pkg::CMD_TICK, 32'd100));
    script.push_back(tick_row(bcpt_pkg::CMD_TICK, 32'd1250));
    // Tempo 1000, then tempo zero, then all ten bits set (the fastest tempo).
    script.push_back(cfg_row(bcpt_pkg::REG_TEMPO, 32'd1000));
    script.push_back(tick_row(bcpt_pkg::CMD_TICK, 32'd1310));
    script.push_back(tick_row(bcpt_pkg::CMD_TICK, 32'd1370));
    script.push_back(cfg_row(bcpt_pkg::REG_TEMPO, 32'd0));
    script.push_back(tick_row(bcpt_pkg::CMD_TICK, 32'd61370));
    script.push_back(tick_row(bcpt_pkg::CMD_TICK, 32'd61371));
    script.push_back(cfg_row(bcpt_pkg::REG_TEMPO, 32'd1023));
    script.push_back(tick_row(bcpt_pkg::CMD_TICK, 32'd61429));
    // Sound mode: triggers count, the next tick shows the pulse.
    script.push_back(cfg_row(bcpt_pkg::REG_SOURCE, 32'd1));
    script.push_back(tick_row(bcpt_pkg::CMD_TICK, 32'hAAAA_AAAA));
    script.push_back(tick_row(bcpt_pkg::CMD_TRIGGER, 32'h0000_0000));
    script.push_back(tick_row(bcpt_pkg::CMD_TRIGGER, 32'h5555_5555));
    script.push_back(tick_row(bcpt_pkg::CMD_TICK, 32'h5555_5555));
    script.push_back(tick_row(bcpt_pkg::CMD_TICK, 32'h0000_0000));
    script.push_back(cfg_row(bcpt_pkg::REG_SOURCE, 32'd0));
    script.push_back(cfg_row(bcpt_pkg::REG_TEMPO, 32'd1));
    script.push_back(tick_row(bcpt_pkg::CMD_TICK, 32'd0));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      if (script[i].is_cfg) write_register(script[i].reg_sel, script[i].value);
      else apply_item(script[i].cmd, script[i].now_ms, script[i].typed, script[i].want);
    end

    cur_ms = 32'd70000;
    for (phase_idx = 0; phase_idx < PHASE_COUNT; phase_idx++) begin
      pick = $urandom_range(0, 5);
      case (pick)
        0: bpm_pick = 32'd0;
        1: bpm_pick = 32'd1;
        2: bpm_pick = 32'd1000;
        3: bpm_pick = 32'd1023;
        default: bpm_pick = $urandom_range(1, 1000);
      endcase
      write_register(bcpt_pkg::REG_TEMPO, bpm_pick);
      write_register(bcpt_pkg::REG_SOURCE, ($urandom_range(0, 9) < 3) ? 32'd1 : 32'd0);
      ivl = tempo_interval_ms();
      // Start some phases just below the wrap point of the time counter.
      if ($urandom_range(0, 2) == 0) cur_ms = 32'hFFFF_FFFF - $urandom_range(0, 4 * ivl);
      sent = 0;
      while (sent < RANDOM_ITEMS / PHASE_COUNT) begin
        pick = $urandom_range(0, 99);
        cmd = bcpt_pkg::CMD_TICK;
        if (pick < ((source_reg == bcpt_pkg::SRC_SOUND) ? 35 : 4)) begin
          cmd = bcpt_pkg::CMD_TRIGGER;
          now = $urandom;
        end else if (pick < 40) begin
          now = $urandom;
          cur_ms = now;
        end else if (pick < 44) begin
          now = cur_ms - $urandom_range(1, ivl);
        end else begin
          cur_ms = cur_ms + $urandom_range(0, ivl + ivl / 4 + 1);
          now = cur_ms;
        end
        // Noise jumps must stay rare next to the steady forward steps.
        if (cmd == bcpt_pkg::CMD_TICK && pick >= 8 && pick < 40) begin
          cur_ms = cur_ms + $urandom_range(0, ivl + ivl / 4 + 1);
          now = cur_ms;
        end
        apply_item(cmd, now, 1'b0, '0);
        if (!(cmd == bcpt_pkg::CMD_TRIGGER && source_reg == bcpt_pkg::SRC_TEMPO)) sent++;
      end
    end

    in_ch.valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
